// ----- hdl/rc4kc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the RC4 key trial checker: shared types, command and status
// structs, register map codes and fixed sizes. No dependencies.
package rc4kc_pkg;

  localparam int BYTE_W  = 8;
  localparam int KEY_W   = 40;
  localparam int TGT_W   = 128;
  localparam int LEN_W   = 5;
  localparam int TBL_AW  = 8;
  localparam int TBL_DEPTH = 256;

  localparam logic [TBL_AW-1:0] TBL_LAST_IDX  = 8'hFF;
  localparam logic [LEN_W-1:0]  CMP_LEN_RESET = 5'd16;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TGT_LO  = 2'd0;
  localparam logic [1:0] REG_TGT_HI  = 2'd1;
  localparam logic [1:0] REG_CMP_LEN = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCH_RDI,
    ST_SCH_RDJ,
    ST_SCH_WRI,
    ST_SCH_WRJ,
    ST_GEN_RDX,
    ST_GEN_RDY,
    ST_GEN_WRX,
    ST_GEN_WRY,
    ST_GEN_CMP,
    ST_FINISH
  } rc4kc_state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SCH_RDI,
    OP_SCH_RDJ,
    OP_SCH_WRI,
    OP_SCH_WRJ,
    OP_GEN_RDX,
    OP_GEN_RDY,
    OP_GEN_WRX,
    OP_GEN_WRY,
    OP_GEN_CMP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic sched_last;  // schedule index at 255
    logic gen_last;    // current keystream byte is the last one compared
    logic byte_ok;     // keystream byte equals target byte
    logic len_zero;    // nothing to compare
  } dp_status_t;

endpackage

// ----- hdl/rc4_key_trial_check.sv -----
`timescale 1ns / 1ps
// RC4 key trial checker, top level: configuration registers, result register,
// controller and datapath. Depends on rc4kc_pkg, rc4kc_ctrl and rc4kc_dp.
//
// Usage:
//   Input channel s_*: one 40-bit candidate key per item. The block runs the
//   RC4 key schedule over a 256-byte permutation, then generates keystream
//   bytes and compares them with the target set over the register port.
//   Output channel m_*: one item per key, the key in tdata and the match flag
//   in tuser.
//   Register port: 64-bit APB-style; target low at 0x00, target high at 0x08,
//   compare length at 0x10. Write registers only while no key is in flight.
// Sequence:
//   After acceptance the block runs the schedule: SCH_RDI once, then per
//   swap SCH_RDJ, SCH_WRI and SCH_WRJ. Then GEN_RDX once, and per keystream
//   byte GEN_RDY, GEN_WRX, GEN_WRY and GEN_CMP, stopping at the first
//   mismatch or after the last byte compared; with length zero no keystream
//   is generated. The table, one read and one write a cycle, sets this split.
//   One key is worked at a time; the next is accepted in the cycle after the
//   result is loaded.
// Reset clears the controller, the result valid flag and the registers to
// their defaults (compare length 16). The table needs no clear: entries not
// yet written for the current key read as their index.
// Receiver stall: the result register holds the result; a key may be
// accepted and worked while it waits, and the finished result then holds
// in the block until the register frees.
module rc4_key_trial_check
  import rc4kc_pkg::*;
#(
  parameter int KEY_BYTES = 5,
  parameter int MAX_COMPARE_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [39:0] candidate_key
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [39:0] tested_key
  output logic [0:0]  m_tuser,   // [0] key_matches
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0]       tgt_lo;
  logic [63:0]       tgt_hi;
  logic [LEN_W-1:0]  cmp_len;
  logic              cfg_wr;
  logic [1:0]        reg_idx;

  logic              res_valid;
  logic              res_match_q;
  logic [KEY_W-1:0]  res_key;

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic              out_free;
  logic              res_load;
  logic              res_match;
  logic [KEY_W-1:0]  cur_key;

  // Register port: always ready, write on the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_lo  <= '0;
      tgt_hi  <= '0;
      cmp_len <= CMP_LEN_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TGT_LO:  tgt_lo  <= pwdata;
        REG_TGT_HI:  tgt_hi  <= pwdata;
        REG_CMP_LEN: cmp_len <= pwdata[LEN_W-1:0];
        default: ;   // addresses past the map are dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TGT_LO:  prdata = tgt_lo;
      REG_TGT_HI:  prdata = tgt_hi;
      REG_CMP_LEN: prdata = {{(64-LEN_W){1'b0}}, cmp_len};
      default:     prdata = '0;
    endcase
  end

  // Result register: frees when empty or taken this cycle
  assign out_free = !res_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_match_q <= res_match;
      res_key     <= cur_key;
    end
  end

  assign m_tvalid   = res_valid;
  assign m_tdata    = res_key;
  assign m_tuser[0] = res_match_q;

  rc4kc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .out_free  (out_free),
    .status    (status),
    .cmd       (cmd),
    .s_tready  (s_tready),
    .res_load  (res_load),
    .res_match (res_match)
  );

  rc4kc_dp #(
    .KEY_BYTES         (KEY_BYTES),
    .MAX_COMPARE_BYTES (MAX_COMPARE_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_key   (s_tdata),
    .target  ({tgt_hi, tgt_lo}),
    .cmp_len (cmp_len),
    .status  (status),
    .key     (cur_key)
  );

  // Once a key is taken, the block is busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted on back-to-back cycles");

  // A fresh result carries the key that was worked
  a_result_key: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (m_tdata == cur_key))
    else $error("result key differs from the key in work");

  // A result is loaded only when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !res_load)
    else $error("pending result overwritten");

endmodule

// ----- hdl/rc4kc_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the RC4 key trial checker: permutation table memory with
// written flags, schedule and generator indexes, key byte select and compare.
// Depends on rc4kc_pkg.
module rc4kc_dp
  import rc4kc_pkg::*;
#(
  parameter int KEY_BYTES = 5,
  parameter int MAX_COMPARE_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  input  logic [KEY_W-1:0]  s_key,
  input  logic [TGT_W-1:0]  target,
  input  logic [LEN_W-1:0]  cmp_len,
  output dp_status_t        status,
  output logic [KEY_W-1:0]  key
);

  localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int N_W    = (MAX_COMPARE_BYTES > 1) ? $clog2(MAX_COMPARE_BYTES) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_COMPARE_BYTES);
  localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_BYTES - 1);

  logic [BYTE_W-1:0] mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] written;
  logic [BYTE_W-1:0] rd;
  logic              rd_flag;
  logic [TBL_AW-1:0] ra_q;

  logic [TBL_AW-1:0] i;
  logic [TBL_AW-1:0] j;
  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic [KIDX_W-1:0] kidx;
  logic [N_W-1:0]    n;

  logic [TBL_AW-1:0] ra;
  logic              we;
  logic [TBL_AW-1:0] wa;
  logic [BYTE_W-1:0] wd;
  logic [BYTE_W-1:0] sval;
  logic [BYTE_W-1:0] kb;
  logic [TBL_AW-1:0] jn;
  logic [63:0]       key_wide;
  logic [5:0]        kshift;
  logic [6:0]        tbit;
  logic [BYTE_W-1:0] tgt_byte;
  logic [LEN_W-1:0]  eff_len;

  // Entry never written since the item started reads as its own index
  assign sval = rd_flag ? rd : ra_q;

  assign key_wide = {{(64-KEY_W){1'b0}}, key};
  assign kshift   = 6'((KEY_BYTES - 1 - int'(kidx)) * 8);
  assign kb       = key_wide[kshift +: 8];
  assign jn       = j + kb + sval;

  assign tbit     = 7'(n) << 3;
  assign tgt_byte = target[tbit +: 8];
  assign eff_len  = (cmp_len > MAX_LEN) ? MAX_LEN : cmp_len;

  assign status.sched_last = (i == TBL_LAST_IDX);
  assign status.gen_last   = ((LEN_W'(n) + LEN_W'(1)) == eff_len);
  assign status.byte_ok    = (sval == tgt_byte);
  assign status.len_zero   = (eff_len == '0);

  always_comb begin
    ra = i;
    we = 1'b0;
    wa = i;
    wd = sval;
    case (cmd.op)
      OP_SCH_RDI: ra = i;
      OP_SCH_RDJ: ra = jn;
      OP_SCH_WRI: begin
        we = 1'b1;
        wa = i;
        wd = sval;
      end
      OP_SCH_WRJ: begin
        we = 1'b1;
        wa = j;
        wd = a;
        ra = i + 8'd1;
      end
      OP_GEN_RDX: ra = i + 8'd1;
      OP_GEN_RDY: ra = j + sval;
      OP_GEN_WRX: begin
        we = 1'b1;
        wa = i;
        wd = sval;
      end
      OP_GEN_WRY: begin
        we = 1'b1;
        wa = j;
        wd = a;
        ra = a + b;
      end
      OP_GEN_CMP: ra = i + 8'd1;
      default: ra = i;
    endcase
  end

  // Table memory: one write and one registered read per cycle, write-first
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd   <= (we && wa == ra) ? wd : mem[ra];
    ra_q <= ra;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_flag <= 1'b0;
    end else if (cmd.op == OP_LOAD) begin
      written <= '0;
      rd_flag <= 1'b0;
    end else begin
      rd_flag <= written[ra] | (we && wa == ra);
      if (we) begin
        written[wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        key  <= s_key;
        i    <= '0;
        j    <= '0;
        kidx <= '0;
        n    <= '0;
      end
      OP_SCH_RDJ: begin
        a <= sval;
        j <= jn;
      end
      OP_SCH_WRJ: begin
        i    <= i + 8'd1;
        kidx <= (kidx == KIDX_LAST) ? '0 : kidx + KIDX_W'(1);
        if (i == TBL_LAST_IDX) begin
          j <= '0;
        end
      end
      OP_GEN_RDX: i <= i + 8'd1;
      OP_GEN_RDY: begin
        a <= sval;
        j <= j + sval;
      end
      OP_GEN_WRX: b <= sval;
      OP_GEN_CMP: begin
        i <= i + 8'd1;
        n <= n + N_W'(1);
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/rc4kc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the RC4 key trial checker: sequences the key schedule and
// keystream compare, tracks the match flag. Depends on rc4kc_pkg.
module rc4kc_ctrl
  import rc4kc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       out_free,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       s_tready,
  output logic       res_load,
  output logic       res_match
);

  rc4kc_state_t state;
  rc4kc_state_t state_next;
  logic         matched;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_SCH_RDI;
      ST_SCH_RDI: state_next = ST_SCH_RDJ;
      ST_SCH_RDJ: state_next = ST_SCH_WRI;
      ST_SCH_WRI: state_next = ST_SCH_WRJ;
      ST_SCH_WRJ: begin
        if (!status.sched_last) state_next = ST_SCH_RDJ;
        else if (status.len_zero) state_next = ST_FINISH;
        else state_next = ST_GEN_RDX;
      end
      ST_GEN_RDX: state_next = ST_GEN_RDY;
      ST_GEN_RDY: state_next = ST_GEN_WRX;
      ST_GEN_WRX: state_next = ST_GEN_WRY;
      ST_GEN_WRY: state_next = ST_GEN_CMP;
      ST_GEN_CMP: begin
        if (!status.byte_ok || status.gen_last) state_next = ST_FINISH;
        else state_next = ST_GEN_RDY;
      end
      ST_FINISH:  if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = OP_NOP;
    s_tready  = 1'b0;
    res_load  = 1'b0;
    res_match = matched;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) cmd.op = OP_LOAD;
      end
      ST_SCH_RDI: cmd.op = OP_SCH_RDI;
      ST_SCH_RDJ: cmd.op = OP_SCH_RDJ;
      ST_SCH_WRI: cmd.op = OP_SCH_WRI;
      ST_SCH_WRJ: cmd.op = OP_SCH_WRJ;
      ST_GEN_RDX: cmd.op = OP_GEN_RDX;
      ST_GEN_RDY: cmd.op = OP_GEN_RDY;
      ST_GEN_WRX: cmd.op = OP_GEN_WRX;
      ST_GEN_WRY: cmd.op = OP_GEN_WRY;
      ST_GEN_CMP: cmd.op = OP_GEN_CMP;
      ST_FINISH:  res_load = out_free;
      default:    cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      matched <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && s_tvalid) begin
        matched <= 1'b1;
      end else if (state == ST_GEN_CMP && !status.byte_ok) begin
        matched <= 1'b0;
      end
    end
  end

endmodule

// ----- tb/sv/tb_rc4_key_trial_check.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rc4_key_trial_check: candidate keys in, match
// verdicts out, checked against a keystream predictor held in a small class.
// Depends on rc4kc_pkg and the rc4_key_trial_check RTL.
module tb_rc4_key_trial_check;
  import rc4kc_pkg::*;

  localparam int KEY_BYTES      = 5;
  localparam int MAX_CMP_BYTES  = 16;
  localparam int QUIET_LIMIT    = 5000;  // quiet cycles before the watchdog ends the run
  localparam int TAIL_CYCLES    = 900;
  localparam int KEY_TARGET     = 1100;

  typedef struct {
    logic              key_match;
    logic [KEY_W-1:0]  key;
  } key_verdict_t;

  // Predictor: own copy of the permutation and of the three registers; one
  // expected verdict per accepted key, checked in order.
  class trial_verdicts;
    logic [7:0]        perm [TBL_DEPTH];
    logic [TGT_W-1:0]  target_stream;
    logic [LEN_W-1:0]  cmp_len;
    key_verdict_t      awaited_verdicts [$];
    int                errors;

    function new();
      target_stream = '0;
      cmp_len       = CMP_LEN_RESET;
      errors        = 0;
    endfunction

    function void set_reg(input logic [4:0] addr, input logic [63:0] value);
      case (addr[4:3])
        REG_TGT_LO:  target_stream[63:0]   = value;
        REG_TGT_HI:  target_stream[127:64] = value;
        REG_CMP_LEN: cmp_len               = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Key schedule over the identity, then the first 16 keystream bytes,
    // byte n in bits 8n+7..8n.
    function logic [TGT_W-1:0] keystream16(input logic [KEY_W-1:0] key);
      logic [7:0]       kb [KEY_BYTES];
      logic [63:0]      key64;
      logic [7:0]       a, b;
      logic [TGT_W-1:0] ks;
      int unsigned      i, j, x, y;
      key64 = 64'(key);
      for (i = 0; i < KEY_BYTES; i++)
        kb[i] = 8'(key64 >> (8 * (KEY_BYTES - 1 - i)));
      for (i = 0; i < TBL_DEPTH; i++)
        perm[i] = 8'(i);
      j = 0;
      for (i = 0; i < TBL_DEPTH; i++) begin
        a = perm[i];
        j = (j + kb[i % KEY_BYTES] + a) & 8'hFF;
        perm[i] = perm[j];
        perm[j] = a;
      end
      x = 0;
      y = 0;
      for (i = 0; i < MAX_CMP_BYTES; i++) begin
        x = (x + 1) & 8'hFF;
        a = perm[x];
        y = (y + a) & 8'hFF;
        b = perm[y];
        perm[x] = b;
        perm[y] = a;
        ks[8*i +: 8] = perm[(a + b) & 8'hFF];
      end
      return ks;
    endfunction

    function void note_key(input logic [KEY_W-1:0] key);
      logic [TGT_W-1:0] ks;
      key_verdict_t     v;
      int unsigned      len, n;
      ks  = keystream16(key);
      // lengths above the maximum saturate; zero compares nothing
      len = (cmp_len > MAX_CMP_BYTES) ? MAX_CMP_BYTES : cmp_len;
      v.key_match = 1'b1;
      v.key       = key;
      for (n = 0; n < len; n++) begin
        if (ks[8*n +: 8] != target_stream[8*n +: 8]) begin
          v.key_match = 1'b0;
          break;
        end
      end
      awaited_verdicts.push_back(v);
    endfunction

    function void check_verdict(input logic match_bit, input logic [KEY_W-1:0] key);
      key_verdict_t v;
      if (awaited_verdicts.size() == 0) begin
        $display("%0t ns: unexpected result: expected none, actual key %h match %b",
                 $time, key, match_bit);
        errors++;
        return;
      end
      v = awaited_verdicts.pop_front();
      if (match_bit !== v.key_match) begin
        $display("%0t ns: key_matches for key %h: expected %b, actual %b",
                 $time, v.key, v.key_match, match_bit);
        errors++;
      end
      if (key !== v.key) begin
        $display("%0t ns: tested_key: expected %h, actual %h", $time, v.key, key);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_verdicts.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [KEY_W-1:0]  s_tdata = '0;   // [39:0] candidate_key
  logic              m_tvalid;
  logic              m_tready = 1'b1;
  logic [KEY_W-1:0]  m_tdata;        // [39:0] tested_key
  logic [0:0]        m_tuser;        // [0] key_matches
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [4:0]        paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;

  trial_verdicts     sb = new();
  int                src_idle_pct = 0;
  int                sink_stall_pct = 0;
  int                sent_keys = 0;
  int                quiet_cycles = 0;

  rc4_key_trial_check #(
    .KEY_BYTES(KEY_BYTES),
    .MAX_COMPARE_BYTES(MAX_CMP_BYTES)
  ) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Receiver: stall at random, one decision per cycle
  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= sink_stall_pct);

  // Monitors: sample handshakes at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst) begin
      if (psel && penable && pwrite && pready)
        sb.set_reg(paddr, pwdata);
      if (s_tvalid && s_tready)
        sb.note_key(s_tdata);
      if (m_tvalid && m_tready)
        sb.check_verdict(m_tuser[0], m_tdata);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[rc4_key_trial_check] ERROR");
      $finish;
    end
  end

  // Offer one key, with random idle cycles ahead of it; hold valid until taken.
  // Valid stays high afterward so back-to-back keys need no extra edge.
  task automatic send_key(input logic [KEY_W-1:0] key);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= KEY_W'({$urandom(), $urandom()});
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
    sent_keys++;
  endtask

  task automatic halt_keys();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_results();
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop valid, let every verdict come home, then load target and length
  task automatic program_target(input logic [TGT_W-1:0] tgt, input logic [LEN_W-1:0] len);
    halt_keys();
    wait_results();
    reg_write(REG_TGT_LO, tgt[63:0]);
    reg_write(REG_TGT_HI, tgt[127:64]);
    reg_write(REG_CMP_LEN, 64'(len));
  endtask

  initial begin
    logic [KEY_W-1:0] secret;
    logic [KEY_W-1:0] key;
    logic [TGT_W-1:0] tgt;
    logic [LEN_W-1:0] len;
    int unsigned      pick;
    int               mode;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset registers (all-zero target, length 16), key extremes
    send_key(40'h00_0000_0000);
    send_key(40'hFF_FFFF_FFFF);
    send_key(40'h80_0000_0000);
    send_key(40'h00_0000_0001);

    // Target set to a known key's keystream: full match, near-miss keys
    secret = 40'h01_2345_6789;
    tgt    = sb.keystream16(secret);
    program_target(tgt, 5'd16);
    send_key(secret);
    send_key(secret ^ 40'h00_0000_0001);
    send_key(secret ^ 40'h80_0000_0000);

    // Mismatch only in the last byte: the whole run of 16 is generated
    program_target(tgt ^ (128'hFF << 120), 5'd16);
    send_key(secret);

    // Byte 7 wrong but only seven bytes compared: still a match
    program_target(tgt ^ (128'h01 << 56), 5'd7);
    send_key(secret);

    // Length zero: every key matches
    program_target(tgt, 5'd0);
    send_key(40'hAA_AAAA_AAAA);
    send_key(40'h55_5555_5555);

    // Lengths above the maximum saturate to 16
    program_target(tgt, 5'd31);
    send_key(secret);
    send_key(40'hFF_FFFF_FFFF);
    program_target(tgt, 5'd17);
    send_key(secret);

    // Single byte compared, then an all-ones target
    program_target(tgt, 5'd1);
    send_key(secret);
    program_target('1, 5'd16);
    send_key(secret);

    // Random phases: each picks a secret key, a target derived from it
    // (sometimes corrupted, all ones, all zeros or pure noise) and a length, then sends keys that
    // are the secret, the secret with one bit flipped, or random.
    mode = 0;
    while (sent_keys < KEY_TARGET) begin
      case (mode % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
        default: begin src_idle_pct = 14; sink_stall_pct = 14; end
      endcase

      secret = KEY_W'({$urandom(), $urandom()});
      tgt    = sb.keystream16(secret);
      pick   = $urandom_range(99);
      if (pick < 15)
        tgt = {$urandom(), $urandom(), $urandom(), $urandom()};
      else if (pick < 30)
        tgt ^= TGT_W'($urandom_range(255, 1)) << (8 * $urandom_range(15));
      else if (pick < 33)
        tgt = '1;
      else if (pick < 36)
        tgt = '0;

      pick = $urandom_range(99);
      if (pick < 10)
        len = 5'd0;
      else if (pick < 20)
        len = LEN_W'($urandom_range(31, 17));
      else if (pick < 35)
        len = 5'd16;
      else
        len = LEN_W'($urandom_range(16, 1));
      program_target(tgt, len);

      repeat (40) begin
        pick = $urandom_range(99);
        if (pick < 30)
          key = secret;
        else if (pick < 50)
          key = secret ^ (40'd1 << $urandom_range(KEY_W - 1));
        else
          key = KEY_W'({$urandom(), $urandom()});
        send_key(key);
      end
      mode++;
    end

    // Drain: no more keys, wait for every verdict, then a tail for strays
    halt_keys();
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("[rc4_key_trial_check] OK");
    else
      $display("[rc4_key_trial_check] ERROR");
    $finish;
  end

endmodule
